// File: rtl/core/msp_pkg.sv
package msp_pkg;

  localparam int NODES    = 16;
  localparam int IDX_W    = $clog2(NODES);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;
  localparam int MAX_OUT  = 16;
  localparam int OUT_W    = $clog2(MAX_OUT);

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NODES - 1);
  localparam logic [OUT_W-1:0]  LAST_OUT = OUT_W'(MAX_OUT - 1);

  // command codes carried on mode
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_ROUTE = 1'b1;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_RELAX,
    SR_DRAIN
  } srch_state_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_SEARCH,
    TS_EMIT
  } top_state_t;

  // search status back to the command side
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

endpackage

// File: rtl/core/msp_edge_ram.sv
module msp_edge_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [msp_pkg::ADDR_W-1:0]     waddr,
  input  logic [msp_pkg::WEIGHT_W-1:0]   wdata,
  input  logic [msp_pkg::ADDR_W-1:0]     raddr,
  output logic [msp_pkg::WEIGHT_W-1:0]   rdata
);

  logic [msp_pkg::WEIGHT_W-1:0] mem [msp_pkg::NODES * msp_pkg::NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/msp_search.sv
module msp_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [msp_pkg::IDX_W-1:0]      src,
  input  logic [msp_pkg::IDX_W-1:0]      dst,
  output logic [msp_pkg::ADDR_W-1:0]     ram_addr,
  input  logic [msp_pkg::WEIGHT_W-1:0]   ram_rdata,
  input  logic [msp_pkg::IDX_W-1:0]      pred_addr,
  output logic [msp_pkg::IDX_W-1:0]      pred_data,
  output msp_pkg::srch_stat_t            stat
);

  msp_pkg::srch_state_t state, state_next;

  logic [msp_pkg::DIST_W-1:0] distance [msp_pkg::NODES];
  logic [msp_pkg::IDX_W-1:0]  pred     [msp_pkg::NODES];
  logic [msp_pkg::NODES-1:0]  settled;

  logic [msp_pkg::IDX_W-1:0]  k;
  logic [msp_pkg::DIST_W-1:0] dist_k;
  logic [msp_pkg::IDX_W-1:0]  src_q;
  logic [msp_pkg::IDX_W-1:0]  cnt;

  logic                       s1_valid;
  logic [msp_pkg::IDX_W-1:0]  s1_idx;
  logic                       s2_valid;
  logic [msp_pkg::IDX_W-1:0]  s2_idx;
  logic [msp_pkg::DIST_W-1:0] s2_d;
  logic                       s2_elig;

  logic                       best_v;
  logic [msp_pkg::IDX_W-1:0]  best_i;
  logic [msp_pkg::DIST_W-1:0] best_d;

  logic                       start_q;
  logic                       issue;
  logic                       pick;
  logic                       pick_end;

  logic [msp_pkg::DIST_W:0]   sum;
  logic [msp_pkg::DIST_W-1:0] cand;
  logic [msp_pkg::DIST_W-1:0] di;
  logic                       upd;
  logic [msp_pkg::DIST_W-1:0] new_d;
  logic                       elig;
  logic                       take;

  assign start_q   = go && (state == msp_pkg::SR_IDLE);
  assign ram_addr  = {k, cnt};
  assign pred_data = pred[pred_addr];

  // relax unit: saturating add then strict compare against the stored distance
  always_comb begin
    sum   = {1'b0, dist_k} + (msp_pkg::DIST_W + 1)'(ram_rdata);
    cand  = sum[msp_pkg::DIST_W] ? msp_pkg::DIST_INF : sum[msp_pkg::DIST_W-1:0];
    di    = distance[s1_idx];
    upd   = (ram_rdata != '0) && !settled[s1_idx] && (cand < di);
    new_d = upd ? cand : di;
    elig  = !settled[s1_idx] && (new_d != msp_pkg::DIST_INF);
    take  = s2_valid && s2_elig && (!best_v || (s2_d < best_d));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::SR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    pick       = 1'b0;
    pick_end   = 1'b0;
    case (state)
      msp_pkg::SR_IDLE: begin
        if (go && (src != dst)) begin
          state_next = msp_pkg::SR_RELAX;
        end
      end
      msp_pkg::SR_RELAX: begin
        issue = 1'b1;
        if (cnt == msp_pkg::LAST_IDX) begin
          state_next = msp_pkg::SR_DRAIN;
        end
      end
      msp_pkg::SR_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          pick     = 1'b1;
          pick_end = !best_v || (best_i == src_q);
          state_next = pick_end ? msp_pkg::SR_IDLE : msp_pkg::SR_RELAX;
        end
      end
      default: state_next = msp_pkg::SR_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      best_v     <= 1'b0;
      stat.done  <= 1'b0;
      stat.found <= 1'b0;
      settled    <= '0;
    end else begin
      s1_valid   <= issue;
      s2_valid   <= s1_valid;
      stat.done  <= (start_q && (src == dst)) || pick_end;
      stat.found <= pick_end && best_v;
      if (start_q || pick) begin
        best_v <= 1'b0;
      end else if (take) begin
        best_v <= 1'b1;
      end
      if (start_q) begin
        settled <= {{(msp_pkg::NODES-1){1'b0}}, 1'b1} << dst;
      end else if (pick && best_v) begin
        settled[best_i] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_q) begin
      for (int i = 0; i < msp_pkg::NODES; i++) begin
        distance[i] <= (i == int'(dst)) ? '0 : msp_pkg::DIST_INF;
        pred[i]     <= (i == int'(dst)) ? dst : '0;
      end
      k             <= dst;
      dist_k        <= '0;
      src_q         <= src;
      cnt           <= '0;
    end else begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (s1_valid && upd) begin
        distance[s1_idx] <= cand;
        pred[s1_idx]     <= k;
      end
      if (pick && best_v) begin
        k      <= best_i;
        dist_k <= best_d;
        cnt    <= '0;
      end
    end
    s1_idx  <= cnt;
    s2_idx  <= s1_idx;
    s2_d    <= new_d;
    s2_elig <= elig;
    if (take) begin
      best_i <= s2_idx;
      best_d <= s2_d;
    end
  end

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> (state == msp_pkg::SR_IDLE))
    else $error("search started while busy");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("min stage fired without a relax beat");

  a_pick_unsettled: assert property (@(posedge clk) disable iff (rst)
    (pick && best_v) |-> !settled[best_i])
    else $error("picked a node that is already settled");

  a_found_settled: assert property (@(posedge clk) disable iff (rst)
    (stat.done && stat.found) |-> settled[src_q])
    else $error("route reported before the source settled");

endmodule

// File: rtl/core/matrix_shortest_path_router_core.sv
// Channel   Ports                                          Handshake
// -------   --------------------------------------------   ----------------------------
// command   mode edge_row edge_col edge_weight             beat at start && !busy
//           source_node target_node
// result    path_node found last                           beat at result_valid, 1 cycle
//
// An edge write leaves busy low.
// A route query holds busy high for the whole search: each Dijkstra round
// streams one row of the edge RAM through the relax/min unit (16 reads,
// a 2-stage drain and the pick), up to NODES-1 rounds, then one result
// per cycle for the path.
// Reset is synchronous on rst; it idles the sequencers but leaves the edge
// RAM contents undefined until written.
// The receiver cannot stall: every result is valid for exactly one cycle.
module matrix_shortest_path_router_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [msp_pkg::IDX_W-1:0]      edge_row,
  input  logic [msp_pkg::IDX_W-1:0]      edge_col,
  input  logic [msp_pkg::WEIGHT_W-1:0]   edge_weight,
  input  logic [msp_pkg::IDX_W-1:0]      source_node,
  input  logic [msp_pkg::IDX_W-1:0]      target_node,
  output logic                           result_valid,
  output logic [msp_pkg::IDX_W-1:0]      path_node,
  output logic                           found,
  output logic                           last
);

  msp_pkg::top_state_t state, state_next;

  logic                           accept;
  logic                           ram_we;
  logic                           go;
  logic [msp_pkg::ADDR_W-1:0]     ram_raddr;
  logic [msp_pkg::WEIGHT_W-1:0]   ram_rdata;
  logic [msp_pkg::IDX_W-1:0]      pred_data;
  msp_pkg::srch_stat_t            stat;

  logic [msp_pkg::IDX_W-1:0]      walk_k;
  logic [msp_pkg::OUT_W-1:0]      walk_n;
  logic [msp_pkg::IDX_W-1:0]      dst_q;
  logic                           nf_emit;
  logic                           path_emit;
  logic                           at_end;

  // take a command beat only while idle
  assign busy   = (state != msp_pkg::TS_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (mode == msp_pkg::MODE_EDGE);
  assign go     = accept && (mode == msp_pkg::MODE_ROUTE);

  // path ends at the target or at the result cap
  assign at_end = (walk_k == dst_q) || (walk_n == msp_pkg::LAST_OUT);

  msp_edge_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({edge_row, edge_col}),
    .wdata (edge_weight),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msp_search u_search (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .src       (source_node),
    .dst       (target_node),
    .ram_addr  (ram_raddr),
    .ram_rdata (ram_rdata),
    .pred_addr (walk_k),
    .pred_data (pred_data),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    nf_emit    = 1'b0;
    path_emit  = 1'b0;
    case (state)
      msp_pkg::TS_IDLE: begin
        if (go) begin
          state_next = msp_pkg::TS_SEARCH;
        end
      end
      msp_pkg::TS_SEARCH: begin
        // wait for the search, then either walk the path or report a miss
        if (stat.done) begin
          if (stat.found) begin
            state_next = msp_pkg::TS_EMIT;
          end else begin
            nf_emit    = 1'b1;
            state_next = msp_pkg::TS_IDLE;
          end
        end
      end
      msp_pkg::TS_EMIT: begin
        path_emit = 1'b1;
        if (at_end) begin
          state_next = msp_pkg::TS_IDLE;
        end
      end
      default: state_next = msp_pkg::TS_IDLE;
    endcase
  end

  // walk predecessors from the source toward the target
  always_ff @(posedge clk) begin
    if (go) begin
      walk_k <= source_node;
      walk_n <= '0;
      dst_q  <= target_node;
    end else if (path_emit) begin
      walk_k <= pred_data;
      walk_n <= walk_n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= nf_emit || path_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (nf_emit) begin
      path_node <= '0;
      found     <= 1'b0;
      last      <= 1'b1;
    end else if (path_emit) begin
      path_node <= walk_k;
      found     <= 1'b1;
      last      <= at_end;
    end
  end

endmodule
